// File: design/second_chance_page_replacement_macros.svh
// Assertion macros used by the second-chance replacement top-level design file.
`ifndef SECOND_CHANCE_PAGE_REPLACEMENT_MACROS_SVH
`define SECOND_CHANCE_PAGE_REPLACEMENT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/scp_pkg.sv
// Package with shared constants, types and the sequencer states of the replacement block.
package scp_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;
    localparam int CFG_W         = 4;
    localparam int PAGE_PORT_W   = 16;
    localparam int COUNT_W       = 16;
    localparam int IDX_MAX_W     = 6;
    localparam int OUT_TDATA_W   = 40;

    localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;
    localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RST = 4'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_INSTALL,
        ST_DONE
    } scp_state_t;

    // Update command for the frame status bits.
    typedef struct packed {
        logic                 clear_all;
        logic                 set_ref;
        logic                 clr_ref;
        logic                 install;
        logic [IDX_MAX_W-1:0] idx;
    } scp_status_cmd_t;

endpackage

// File: design/scp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module scp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/scp_status.sv
// Valid marks and reference bits of all page frames, held in flip-flops.
module scp_status #(
    parameter int FRAMES = scp_pkg::FRAMES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  scp_pkg::scp_status_cmd_t cmd,
    output logic [FRAMES-1:0]       frame_valid,
    output logic [FRAMES-1:0]       reference_bit
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic [FRAMES-1:0] valid_reg;
    logic [FRAMES-1:0] ref_reg;
    logic [IDX_W-1:0]  idx;

    assign idx = cmd.idx[IDX_W-1:0];

    // A new trace empties every frame; otherwise one frame is updated per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ref_reg   <= '0;
        end
        else if (cmd.clear_all)
        begin
            valid_reg <= '0;
            ref_reg   <= '0;
        end
        else
        begin
            if (cmd.set_ref)
            begin
                ref_reg[idx] <= 1'b1;
            end
            if (cmd.clr_ref)
            begin
                ref_reg[idx] <= 1'b0;
            end
            if (cmd.install)
            begin
                valid_reg[idx] <= 1'b1;
                ref_reg[idx]   <= 1'b1;
            end
        end
    end

    assign frame_valid   = valid_reg;
    assign reference_bit = ref_reg;

endmodule

// File: design/second_chance_page_replacement.sv
// On a hit the lookup ends at the matching frame; on a fault it searches all n managed frames,
// then the clock hand sweeps for 1 .. n + 1 steps before the victim is installed.
// The page lookup reads the frame RAM one frame per cycle, and the clock hand
// then steps one frame per cycle; one reference is in work at a time.
// Reset (rst_n low, asynchronous) empties all frames, zeroes hand and count, sets 4 frames.
`include "second_chance_page_replacement_macros.svh"

module second_chance_page_replacement #(
    parameter int FRAMES    = scp_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = scp_pkg::PAGE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input references.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [scp_pkg::PAGE_PORT_W-1:0]   s_tdata,   // [15:0] page_number
    input  logic [0:0]                        s_tuser,   // [0] new_trace
    input  logic                              s_tlast,   // last_reference
    // Results.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] fault, [3:1] frame_index, [4] victim_valid, [20:5] victim_page,
    // [36:21] fault_count, [39:37] zero
    output logic [scp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,   // trace_end
    // Configuration: frames_in_use.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scp_pkg::CFG_W-1:0]         cfg_data
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    scp_pkg::scp_state_t state_reg, state_next;

    logic [scp_pkg::CFG_W-1:0]   frames_cfg_reg;
    logic [CNT_W-1:0]            managed;
    logic [CNT_W-1:0]            n_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic                        cmp_pending_reg;
    logic [IDX_W-1:0]            cmp_idx_reg;
    logic [IDX_W-1:0]            hand_reg;
    logic [IDX_W-1:0]            sweep_h_reg;
    logic [IDX_W-1:0]            slot_reg;
    logic [PAGE_BITS-1:0]        page_reg;
    logic                        last_reg;
    logic                        hit_reg;
    logic                        vvalid_reg;
    logic [PAGE_BITS-1:0]        vpage_reg;
    logic [scp_pkg::COUNT_W-1:0] count_reg;
    logic                        m_tvalid_reg;
    logic [scp_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                        m_tlast_reg;

    logic [31:0]          page_wide;
    logic [PAGE_BITS-1:0] page_key;
    logic [31:0]          slot_wide;
    logic [31:0]          vpage_wide;

    logic accept;
    logic match;
    logic lookup_miss;
    logic sweep_busy;
    logic output_free;

    logic                 ram_we;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [PAGE_BITS-1:0] ram_rdata;

    logic [FRAMES-1:0]        frame_valid;
    logic [FRAMES-1:0]        reference_bit;
    scp_pkg::scp_status_cmd_t status_cmd;
    logic [IDX_W-1:0]         status_idx;

    // Next frame along the clock, wrapping at the managed count.
    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] h,
                                                   input logic [CNT_W-1:0] n);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(h) + 1'b1;
        if (s >= {1'b0, n})
        begin
            return '0;
        end
        return s[IDX_W-1:0];
    endfunction

    // Configuration register; the user keeps writes to idle; the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_cfg_reg <= scp_pkg::FRAMES_IN_USE_RST;
        end
        else if (cfg_valid)
        begin
            frames_cfg_reg <= cfg_data;
        end
    end

    // Managed frame count: zero manages one frame, large values clamp to the build size.
    always_comb
    begin
        if (frames_cfg_reg == '0)
        begin
            managed = CNT_W'(1);
        end
        else if (int'(frames_cfg_reg) > FRAMES)
        begin
            managed = CNT_W'(FRAMES);
        end
        else
        begin
            managed = CNT_W'(frames_cfg_reg);
        end
    end

    // Page key taken modulo the stored page width.
    assign page_wide = 32'(s_tdata);
    assign page_key  = page_wide[PAGE_BITS-1:0];

    // Handshake and step conditions.
    assign s_tready    = (state_reg == scp_pkg::ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign match       = (state_reg == scp_pkg::ST_LOOKUP) && cmp_pending_reg
                         && frame_valid[cmp_idx_reg] && (ram_rdata == page_reg);
    assign lookup_miss = (state_reg == scp_pkg::ST_LOOKUP) && !match
                         && cmp_pending_reg && (idx_reg == n_reg);
    assign sweep_busy  = frame_valid[sweep_h_reg] && reference_bit[sweep_h_reg];
    assign output_free = !m_tvalid_reg || m_tready;

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, RAM port and status commands.
    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg[IDX_W-1:0];
        status_idx = slot_reg;
        status_cmd = '0;
        case (state_reg)
            scp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    status_cmd.clear_all = s_tuser[0];
                    state_next = scp_pkg::ST_LOOKUP;
                end
            end
            scp_pkg::ST_LOOKUP:
            begin
                ram_re = (idx_reg < n_reg);
                if (match)
                begin
                    status_cmd.set_ref = 1'b1;
                    status_idx = cmp_idx_reg;
                    state_next = scp_pkg::ST_DONE;
                end
                else if (lookup_miss)
                begin
                    state_next = scp_pkg::ST_SWEEP;
                end
            end
            scp_pkg::ST_SWEEP:
            begin
                ram_raddr  = sweep_h_reg;
                status_idx = sweep_h_reg;
                if (sweep_busy)
                begin
                    status_cmd.clr_ref = 1'b1;
                end
                else
                begin
                    ram_re = 1'b1;
                    state_next = scp_pkg::ST_INSTALL;
                end
            end
            scp_pkg::ST_INSTALL:
            begin
                ram_we = 1'b1;
                status_cmd.install = 1'b1;
                state_next = scp_pkg::ST_DONE;
            end
            scp_pkg::ST_DONE:
            begin
                if (output_free)
                begin
                    state_next = scp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scp_pkg::ST_IDLE;
            end
        endcase
        status_cmd.idx = scp_pkg::IDX_MAX_W'(status_idx);
    end

    // Control registers: hand, fault count, lookup pipeline and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hand_reg        <= '0;
            count_reg       <= '0;
            cmp_pending_reg <= 1'b0;
            idx_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                scp_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg         <= '0;
                        cmp_pending_reg <= 1'b0;
                        if (s_tuser[0])
                        begin
                            hand_reg  <= '0;
                            count_reg <= '0;
                        end
                    end
                end
                scp_pkg::ST_LOOKUP:
                begin
                    cmp_pending_reg <= (idx_reg < n_reg);
                    if (idx_reg < n_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                scp_pkg::ST_INSTALL:
                begin
                    hand_reg <= wrap_next(slot_reg, n_reg);
                    if (count_reg != scp_pkg::COUNT_MAX)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            // A finished reference loads the output; an accepted result empties it.
            if ((state_reg == scp_pkg::ST_DONE) && output_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result field widths as carried on the bus.
    assign slot_wide  = 32'(slot_reg);
    assign vpage_wide = 32'(vpage_reg);

    // Payload registers of the reference in work and of the result.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            scp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    page_reg <= page_key;
                    last_reg <= s_tlast;
                    n_reg    <= managed;
                end
            end
            scp_pkg::ST_LOOKUP:
            begin
                cmp_idx_reg <= idx_reg[IDX_W-1:0];
                if (match)
                begin
                    hit_reg    <= 1'b1;
                    slot_reg   <= cmp_idx_reg;
                    vvalid_reg <= 1'b0;
                    vpage_reg  <= '0;
                end
                else if (lookup_miss)
                begin
                    // A hand left beyond a shrunk frame count restarts at frame zero.
                    sweep_h_reg <= (CNT_W'(hand_reg) >= n_reg) ? '0 : hand_reg;
                end
            end
            scp_pkg::ST_SWEEP:
            begin
                if (sweep_busy)
                begin
                    sweep_h_reg <= wrap_next(sweep_h_reg, n_reg);
                end
                else
                begin
                    slot_reg <= sweep_h_reg;
                end
            end
            scp_pkg::ST_INSTALL:
            begin
                hit_reg    <= 1'b0;
                vvalid_reg <= frame_valid[slot_reg];
                vpage_reg  <= frame_valid[slot_reg] ? ram_rdata : '0;
            end
            scp_pkg::ST_DONE:
            begin
                if (output_free)
                begin
                    m_tdata_reg <= {3'b000, count_reg, vpage_wide[15:0], vvalid_reg,
                                    slot_wide[2:0], !hit_reg};
                    m_tlast_reg <= last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Page numbers of the frames.
    scp_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES)
    ) u_page_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (page_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Valid marks and reference bits.
    scp_status #(
        .FRAMES (FRAMES)
    ) u_status (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (status_cmd),
        .frame_valid   (frame_valid),
        .reference_bit (reference_bit)
    );

    // A finished reference is presented in the following cycle.
    `SCP_ASSERT_NEXT(a_done_presents, (state_reg == scp_pkg::ST_DONE) && output_free, m_tvalid, "result not presented after completion")
    // After an install the hand lies inside the managed frames.
    `SCP_ASSERT_NEXT(a_hand_in_range, state_reg == scp_pkg::ST_INSTALL, CNT_W'(hand_reg) < n_reg, "clock hand outside managed frames")
    // Each fault below saturation raises the count by one.
    `SCP_ASSERT_NEXT(a_count_step, (state_reg == scp_pkg::ST_INSTALL) && (count_reg != scp_pkg::COUNT_MAX), count_reg == $past(count_reg) + 1'b1, "fault count did not advance")
    // The installed frame is always free of a set reference bit.
    `SCP_ASSERT_SAME(a_victim_clear, state_reg == scp_pkg::ST_INSTALL, !(frame_valid[slot_reg] && reference_bit[slot_reg]), "victim frame still referenced")

endmodule
